// ----- sv/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Page cache directory package
// Shared widths, item layouts, result kinds, control codes and the tag entry
// layout of the page cache directory.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam int BACKEND_W  = 2;
  localparam int INODE_W    = 32;
  localparam int DEV_W      = 16;
  localparam int OFF_W      = 48;
  localparam int AGE_W      = 64;
  localparam int IDX_OUT_W  = 6;
  localparam int FILL_W     = 13;
  localparam int RA_W       = 2;
  localparam int KIND_W     = 2;

  // Input tdata: backend, is_directory, is_device_node, inode, device_id,
  // byte_offset, file_size, then zero padding to whole bytes.
  localparam int IN_FIELDS_W = BACKEND_W + 2 + INODE_W + DEV_W + 2 * OFF_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata: entry_index, page_offset, fill_bytes, was_hit, any_cleared.
  localparam int OUT_FIELDS_W = IDX_OUT_W + OFF_W + FILL_W + 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [RA_W-1:0] RA_RESET = 2'd2;
  localparam logic [RA_W-1:0] RA_MAX   = 2'd2;

  localparam logic [BACKEND_W-1:0] BACKEND_RAM  = 2'd0;
  localparam logic [BACKEND_W-1:0] BACKEND_DISK = 2'd1;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_INVAL = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_FILL   = 2'd0,
    KIND_READY  = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_INVAL  = 2'd3
  } kind_t;

  // What the current directory sweep is looking for.
  typedef enum logic [1:0] {
    OP_REQ,
    OP_RA,
    OP_FINAL,
    OP_INVAL
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [BACKEND_W-1:0] backend;
    logic [INODE_W-1:0]   inode;
    logic [DEV_W-1:0]     device;
    logic [OFF_W-1:0]     page;
  } tag_entry_t;

endpackage

// ----- sv/pcd_ram.sv -----
// ----------------------------------------------------------------------------
// Page cache directory RAM
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module pcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/page_cache_directory_lru_readahead.sv -----
// ----------------------------------------------------------------------------
// Page cache directory with LRU replacement and readahead
// Tag directory of a fully associative page cache. Read requests look up the
// requested page and its readahead pages, allocate victims for missing pages
// and issue fill commands; invalidate requests drop every entry of a file.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// s_*      in   s_tvalid/s_tready  request item: tuser = mode, tdata = file key,
//                                  flags, byte offset and file size
// m_*      out  m_tvalid/m_tready  result item: tuser = kind, tlast = last,
//                                  tdata = entry, page, fill bytes, flags
// cfg_*    in   cfg_valid/cfg_ready readahead page count, always ready
//
// Every cacheable read and every invalidate is served by full sweeps over the
// tag and age memories, one entry per cycle through the read port. Each sweep
// is followed by an update step. A read request takes one sweep for the
// requested page, one per readahead page that starts below the file size, up
// to the configured count, at most two, and a final sweep; an invalidate
// takes one sweep, and a rejected request goes straight to its result
// without a sweep. After reset a clearing pass marks every entry invalid;
// s_tready stays low during it. A stalled output holds the block in its emit
// step, and the next request is taken while the final result waits.
// ----------------------------------------------------------------------------
module page_cache_directory_lru_readahead #(
  parameter int ENTRIES    = pcd_pkg::DEF_ENTRIES,
  parameter int PAGE_BYTES = pcd_pkg::DEF_PAGE_BYTES  // must be a power of two
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // backend[1:0], is_directory[2], is_device_node[3], inode[35:4],
  // device_id[51:36], byte_offset[99:52], file_size[147:100], zero pad
  input  logic [pcd_pkg::IN_DATA_W-1:0]   s_tdata,
  // mode[0]
  input  logic [0:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // entry_index[5:0], page_offset[53:6], fill_bytes[66:54], was_hit[67],
  // any_cleared[68], zero pad
  output logic [pcd_pkg::OUT_DATA_W-1:0]  m_tdata,
  // kind[1:0]
  output logic [pcd_pkg::KIND_W-1:0]      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcd_pkg::RA_W-1:0]        cfg_data
);

  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_EXT_W = IDX_W + pcd_pkg::IDX_OUT_W;
  localparam int OFF_W     = pcd_pkg::OFF_W;
  localparam int AGE_W     = pcd_pkg::AGE_W;
  localparam int TAG_W     = $bits(pcd_pkg::tag_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(ENTRIES);
  localparam logic [OFF_W-1:0] PAGE_SIZE = OFF_W'(PAGE_BYTES);
  localparam logic [OFF_W-1:0] PAGE_MASK = ~(PAGE_SIZE - OFF_W'(1));

  // Request fields as they arrive on the slave side.
  logic                            in_mode;
  logic [pcd_pkg::BACKEND_W-1:0]   in_backend;
  logic                            in_is_dir;
  logic                            in_is_dev;
  logic [pcd_pkg::INODE_W-1:0]     in_inode;
  logic [pcd_pkg::DEV_W-1:0]       in_device;
  logic [OFF_W-1:0]                in_offset;
  logic [OFF_W-1:0]                in_size;
  logic                            in_cacheable;

  assign in_mode    = s_tuser[0];
  assign in_backend = s_tdata[1:0];
  assign in_is_dir  = s_tdata[2];
  assign in_is_dev  = s_tdata[3];
  assign in_inode   = s_tdata[35:4];
  assign in_device  = s_tdata[51:36];
  assign in_offset  = s_tdata[99:52];
  assign in_size    = s_tdata[147:100];

  // Only plain files of the ram store or the disk store go into the cache.
  assign in_cacheable = (in_backend == pcd_pkg::BACKEND_RAM ||
                         in_backend == pcd_pkg::BACKEND_DISK) &&
                        !in_is_dir && !in_is_dev;

  // Control state.
  pcd_pkg::state_t state, state_next;
  pcd_pkg::op_t    op;
  logic [IDX_W-1:0]         clr_addr;
  logic [IDX_W:0]           scan_cnt;
  logic                     smp_vld;
  logic [AGE_W-1:0]         stamp;
  logic [pcd_pkg::RA_W-1:0] ra_reg;

  // Request context, held for the whole request.
  logic [pcd_pkg::BACKEND_W-1:0] req_backend;
  logic [pcd_pkg::INODE_W-1:0]   req_inode;
  logic [pcd_pkg::DEV_W-1:0]     req_device;
  logic [OFF_W-1:0]              req_off;
  logic [OFF_W-1:0]              req_size;
  logic [OFF_W-1:0]              cur_page;
  logic [pcd_pkg::RA_W-1:0]      ra_lim;
  logic [pcd_pkg::RA_W-1:0]      ra_cnt;
  logic                          hit;

  // Sweep accumulators.
  logic [IDX_W-1:0] smp_idx;
  logic             match;
  logic [IDX_W-1:0] match_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] lru_idx;
  logic [AGE_W-1:0] lru_age;
  logic             any_key;

  // Pending result, moved to the output register in the emit step.
  pcd_pkg::kind_t   res_kind;
  logic [IDX_W-1:0] res_idx;
  logic [OFF_W-1:0] res_page;
  logic             res_last;

  // Memory ports.
  logic             tag_we;
  logic [IDX_W-1:0] tag_waddr;
  logic [TAG_W-1:0] tag_wdata;
  logic [TAG_W-1:0] tag_rdata;
  logic             age_we;
  logic [IDX_W-1:0] age_waddr;
  logic [AGE_W-1:0] age_wdata;
  logic [AGE_W-1:0] age_rdata;
  logic [IDX_W-1:0] rd_addr;

  pcd_pkg::tag_entry_t smp_tag;
  pcd_pkg::tag_entry_t new_tag;
  pcd_pkg::tag_entry_t drop_tag;

  logic             scan_issue;
  logic             scan_done;
  logic             key_eq;
  logic             page_eq;
  logic             smp_first;
  logic [IDX_W-1:0] victim;
  logic [IDX_W-1:0] act_idx;
  logic [OFF_W:0]   next_ahead;
  logic             ra_go;
  logic [AGE_W-1:0] stamp_new;
  logic             stamp_we;
  logic             emit_go;
  logic [OFF_W-1:0] fill_room;
  logic [OFF_W-1:0] fill_full;
  logic [pcd_pkg::FILL_W-1:0] fill_val;
  logic [IDX_EXT_W-1:0]       res_idx_ext;

  pcd_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (rd_addr),
    .rdata (tag_rdata)
  );

  pcd_ram #(
    .WIDTH (AGE_W),
    .DEPTH (ENTRIES)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (rd_addr),
    .rdata (age_rdata)
  );

  assign s_tready  = (state == pcd_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // The sweep issues one read per cycle; the entry shows up the next cycle.
  assign rd_addr    = scan_cnt[IDX_W-1:0];
  assign scan_issue = (state == pcd_pkg::ST_SCAN) && (scan_cnt != SCAN_END);
  assign scan_done  = smp_vld && (smp_idx == LAST_IDX);
  assign smp_first  = (smp_idx == '0);

  assign smp_tag = pcd_pkg::tag_entry_t'(tag_rdata);
  assign key_eq  = smp_tag.valid && (smp_tag.backend == req_backend) &&
                   (smp_tag.inode == req_inode) && (smp_tag.device == req_device);
  assign page_eq = key_eq && (smp_tag.page == cur_page);

  // Victim: first invalid entry, else the oldest entry.
  assign victim  = free_found ? free_idx : lru_idx;
  assign act_idx = match ? match_idx : victim;

  always_comb begin
    new_tag         = '0;
    new_tag.valid   = 1'b1;
    new_tag.backend = req_backend;
    new_tag.inode   = req_inode;
    new_tag.device  = req_device;
    new_tag.page    = cur_page;
    drop_tag        = smp_tag;
    drop_tag.valid  = 1'b0;
  end

  // Readahead continues while pages remain and the next page starts inside
  // the file. The extra top bit keeps a page past the 48-bit range out.
  assign next_ahead = {1'b0, cur_page} + {1'b0, PAGE_SIZE};
  assign ra_go      = (ra_cnt < ra_lim) && (next_ahead < {1'b0, req_size});

  // A hit on the requested page is stamped twice: once by the hit check and
  // once by the load of that page.
  assign stamp_new = stamp + (((op == pcd_pkg::OP_REQ) && match) ? AGE_W'(2) : AGE_W'(1));

  assign emit_go = (state == pcd_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  // Fill length: the part of the page that lies inside the file.
  assign fill_room = req_size - res_page;
  assign fill_full = (fill_room > PAGE_SIZE) ? PAGE_SIZE : fill_room;
  assign fill_val  = ((res_kind == pcd_pkg::KIND_FILL) && (res_page < req_size)) ?
                     fill_full[pcd_pkg::FILL_W-1:0] : '0;
  assign res_idx_ext = IDX_EXT_W'(res_idx);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pcd_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_IDX) begin
          state_next = pcd_pkg::ST_IDLE;
        end
      end
      pcd_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (in_mode == pcd_pkg::MODE_INVAL || in_cacheable) begin
            state_next = pcd_pkg::ST_SCAN;
          end else begin
            state_next = pcd_pkg::ST_EMIT;
          end
        end
      end
      pcd_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = pcd_pkg::ST_ACT;
        end
      end
      pcd_pkg::ST_ACT: begin
        if (op == pcd_pkg::OP_FINAL || op == pcd_pkg::OP_INVAL || !match) begin
          state_next = pcd_pkg::ST_EMIT;
        end else begin
          state_next = pcd_pkg::ST_SCAN;
        end
      end
      pcd_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = res_last ? pcd_pkg::ST_IDLE : pcd_pkg::ST_SCAN;
        end
      end
      default: begin
        state_next = pcd_pkg::ST_CLEAR;
      end
    endcase
  end

  // Memory writes and age stamping per state.
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = act_idx;
    tag_wdata = TAG_W'(new_tag);
    age_we    = 1'b0;
    age_waddr = act_idx;
    age_wdata = stamp_new;
    stamp_we  = 1'b0;
    case (state)
      pcd_pkg::ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_addr;
        tag_wdata = '0;
      end
      pcd_pkg::ST_SCAN: begin
        // Invalidate drops matching entries as the sweep passes them.
        if (smp_vld && op == pcd_pkg::OP_INVAL && key_eq) begin
          tag_we    = 1'b1;
          tag_waddr = smp_idx;
          tag_wdata = TAG_W'(drop_tag);
        end
      end
      pcd_pkg::ST_ACT: begin
        if (op == pcd_pkg::OP_REQ || op == pcd_pkg::OP_RA) begin
          age_we   = 1'b1;
          stamp_we = 1'b1;
          tag_we   = !match;
        end else if (op == pcd_pkg::OP_FINAL && match) begin
          age_we   = 1'b1;
          stamp_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pcd_pkg::ST_CLEAR;
      clr_addr <= '0;
      scan_cnt <= '0;
      smp_vld  <= 1'b0;
      stamp    <= '0;
      ra_reg   <= pcd_pkg::RA_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      smp_vld <= scan_issue;
      if (cfg_valid && cfg_ready) begin
        ra_reg <= cfg_data;
      end
      if (state == pcd_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else if (state != pcd_pkg::ST_SCAN) begin
        scan_cnt <= '0;
      end
      if (stamp_we) begin
        stamp <= stamp_new;
      end
      // A new item replaces the old one in the same cycle it is taken.
      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Request context, sweep results and the pending result.
  always_ff @(posedge clk) begin
    smp_idx <= rd_addr;

    if (state == pcd_pkg::ST_IDLE && s_tvalid) begin
      req_backend <= in_backend;
      req_inode   <= in_inode;
      req_device  <= in_device;
      req_off     <= in_offset & PAGE_MASK;
      cur_page    <= in_offset & PAGE_MASK;
      req_size    <= in_size;
      op          <= (in_mode == pcd_pkg::MODE_INVAL) ? pcd_pkg::OP_INVAL : pcd_pkg::OP_REQ;
      ra_lim      <= (ra_reg > pcd_pkg::RA_MAX) ? pcd_pkg::RA_MAX : ra_reg;
      ra_cnt      <= '0;
      hit         <= 1'b0;
      res_kind    <= pcd_pkg::KIND_REJECT;
      res_idx     <= '0;
      res_page    <= '0;
      res_last    <= 1'b1;
    end

    if (smp_vld) begin
      if (smp_first || (!match && page_eq)) begin
        match     <= page_eq;
        match_idx <= smp_idx;
      end
      if (smp_first || (!free_found && !smp_tag.valid)) begin
        free_found <= !smp_tag.valid;
        free_idx   <= smp_idx;
      end
      if (smp_first || (age_rdata < lru_age)) begin
        lru_idx <= smp_idx;
        lru_age <= age_rdata;
      end
      any_key <= smp_first ? key_eq : (any_key || key_eq);
    end

    if (state == pcd_pkg::ST_ACT) begin
      case (op)
        pcd_pkg::OP_REQ, pcd_pkg::OP_RA: begin
          if (op == pcd_pkg::OP_REQ) begin
            hit <= match;
          end
          res_kind <= pcd_pkg::KIND_FILL;
          res_idx  <= victim;
          res_page <= cur_page;
          res_last <= 1'b0;
          if (ra_go) begin
            op       <= pcd_pkg::OP_RA;
            cur_page <= next_ahead[OFF_W-1:0];
            ra_cnt   <= ra_cnt + 1'b1;
          end else begin
            op       <= pcd_pkg::OP_FINAL;
            cur_page <= req_off;
          end
        end
        pcd_pkg::OP_FINAL: begin
          // The requested page can be gone if readahead displaced it.
          res_kind <= match ? pcd_pkg::KIND_READY : pcd_pkg::KIND_REJECT;
          res_idx  <= match ? match_idx : '0;
          res_page <= match ? req_off : '0;
          res_last <= 1'b1;
        end
        default: begin
          res_kind <= pcd_pkg::KIND_INVAL;
          res_idx  <= '0;
          res_page <= '0;
          res_last <= 1'b1;
        end
      endcase
    end

    if (emit_go) begin
      m_tuser <= res_kind;
      m_tlast <= res_last;
      m_tdata <= pcd_pkg::OUT_DATA_W'({(res_kind == pcd_pkg::KIND_INVAL) && any_key,
                                       hit, fill_val, res_page,
                                       res_idx_ext[pcd_pkg::IDX_OUT_W-1:0]});
    end
  end

endmodule

// ----- sv/pcd_checker.sv -----
// ----------------------------------------------------------------------------
// Page cache directory checker
// Port-level checks on the page cache directory, attached by bind.
// ----------------------------------------------------------------------------
module pcd_checker #(
  parameter int PAGE_BYTES = pcd_pkg::DEF_PAGE_BYTES
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [pcd_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [pcd_pkg::KIND_W-1:0]     m_tuser,
  input logic                           m_tlast
);

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("result item changed while stalled");

  // Fill commands never close a request; every other kind does.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != pcd_pkg::KIND_FILL)))
    else $error("last flag does not match result kind");

  // A fill never asks for more than one page.
  a_fill_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pcd_pkg::KIND_FILL |-> int'(m_tdata[66:54]) <= PAGE_BYTES)
    else $error("fill length exceeds a page");

  // An invalidate result carries only the cleared flag.
  a_inval_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == pcd_pkg::KIND_INVAL |-> m_tdata[67:0] == '0)
    else $error("invalidate result carries entry data");

  // Requests are served one at a time.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

endmodule

bind page_cache_directory_lru_readahead pcd_checker #(
  .PAGE_BYTES (PAGE_BYTES)
) u_pcd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
